[src/mlp_pkg.sv]
// Package: sizes, store layout, command and job types, sigmoid table.
`default_nettype none
package mlp_pkg;
  localparam int Inputs = 32;
  localparam int Hidden = 16;
  localparam int Classes = 12;
  localparam int OffW1 = 0;
  localparam int OffB1 = OffW1 + Inputs * Hidden;
  localparam int OffW2 = OffB1 + Hidden;
  localparam int OffB2 = OffW2 + Hidden * Hidden;
  localparam int OffW3 = OffB2 + Hidden;
  localparam int OffB3 = OffW3 + Classes * Hidden;
  localparam int StoreDepth = OffB3 + Classes;
  localparam int AddrW = 10;
  localparam int FeatIdxW = 5;
  localparam int ActW = 9;
  localparam int ClassW = 4;
  localparam int AccW = 48;

  typedef enum logic {
    FUNC_PARAM = 1'b0,
    FUNC_FEATURE = 1'b1
  } func_e;

  // queued job from the front end to the compute engine
  typedef struct packed {
    func_e func;
    logic [AddrW-1:0] addr;
    logic [15:0] value;
    logic [FeatIdxW-1:0] fidx;
    logic [ActW-1:0] fval;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_BIAS,
    ST_ACT,
    ST_EMIT
  } eng_state_e;

  function automatic logic [ActW-1:0] sig_lut(input logic [7:0] k);
    int unsigned x;
    int unsigned r;
    logic [ActW-1:0] v;
    x = (k >= 8'd128) ? 32'(k) - 32'd128 : 32'd128 - 32'(k);
    // positive half, rounded 256*sigmoid(x/16)
    unique case (x)
      0: r = 128; 1: r = 132; 2: r = 136; 3: r = 140; 4: r = 144; 5: r = 148;
      6: r = 152; 7: r = 156; 8: r = 159; 9: r = 163; 10: r = 167; 11: r = 170;
      12: r = 174; 13: r = 177; 14: r = 181; 15: r = 184; 16: r = 187;
      17: r = 190; 18: r = 193; 19: r = 196; 20: r = 199; 21: r = 202;
      22: r = 204; 23: r = 207; 24: r = 209; 25: r = 212; 26: r = 214;
      27: r = 216; 28: r = 218; 29: r = 220; 30: r = 222; 31: r = 224;
      32: r = 225; 33: r = 227; 34: r = 229; 35: r = 230; 36: r = 232;
      37: r = 233; 38: r = 234; 39: r = 235; 40: r = 237; 41: r = 238;
      42: r = 239; 43: r = 240; 44: r = 241; 45: r = 241; 46: r = 242;
      47: r = 243; 48: r = 244; 49: r = 245; 50: r = 245; 51: r = 246;
      52: r = 246; 53: r = 247; 54: r = 248; 55: r = 248; 56: r = 248;
      57: r = 249; 58: r = 249; 59: r = 250; 60: r = 250; 61: r = 250;
      62: r = 251; 63: r = 251; 64: r = 251;
      // flat tail: the value only steps at a few points
      default: begin
        if (x >= 32'd100) r = 256;
        else if (x >= 32'd83) r = 255;
        else if (x >= 32'd74) r = 254;
        else if (x >= 32'd69) r = 253;
        else r = 252;
      end
    endcase
    if (k >= 8'd128) v = ActW'(r);
    else v = ActW'(32'd256 - r);
    return v;
  endfunction
endpackage
`default_nettype wire

[src/mlp_front.sv]
// Front end: accepts stream beats, drops out-of-range ones, queues jobs.
`default_nettype none
module mlp_front import mlp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire job_t in_job_i,
  output logic      q_valid_o,
  input  wire logic q_ready_i,
  output job_t      q_job_o
);
  localparam int Depth = 4;
  job_t mem_q [Depth];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic keep, push, pop;

  always_comb begin
    keep = (in_job_i.func == FUNC_PARAM) ? (32'(in_job_i.addr) < StoreDepth)
                                         : (32'(in_job_i.fidx) < Inputs);
  end
  assign in_ready_o = (cnt_q != 3'(Depth));
  assign push = in_valid_i && in_ready_o && keep;
  assign q_valid_o = (cnt_q != 3'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_job_o = mem_q[rd_q];
  assign wr_d = push ? wr_q + 2'd1 : wr_q;
  assign rd_d = pop ? rd_q + 2'd1 : rd_q;
  assign cnt_d = cnt_q + 3'(push) - 3'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_job_i;
  end
endmodule
`default_nettype wire

[src/mlp_engine.sv]
// Back end: weight store, buffers, shared MAC, sigmoid and result output.
`default_nettype none
module mlp_engine import mlp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  output logic      q_ready_o,
  input  wire job_t q_job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [ClassW-1:0] class_index_o,
  output logic [ActW-1:0]   class_score_o,
  output logic [ClassW-1:0] best_class_o,
  output logic [ActW-1:0]   best_score_o,
  output logic              last_o
);
  logic [15:0] wmem [StoreDepth];
  logic [ActW-1:0] feat_q [Inputs];
  logic [ActW-1:0] h1_q [Hidden];
  logic [ActW-1:0] h2_q [Hidden];
  logic [ActW-1:0] sc_q [Classes];

  eng_state_e st_q, st_d;
  logic [1:0] layer_q, layer_d;      // 0..2
  logic [4:0] row_q, row_d;
  logic [5:0] col_q, col_d;          // issue column, n_in means done
  logic       pend_q;                // a read is in flight this cycle
  logic [5:0] pcol_q;
  logic [AddrW-1:0] raddr;
  logic signed [15:0] rdata_q;
  logic signed [AccW-1:0] acc_q;
  logic [ActW-1:0] act_sel;
  logic [5:0] n_in;
  logic [4:0] n_out;
  logic [ClassW-1:0] k_q;
  logic [ClassW-1:0] bc_q;
  logic [ActW-1:0] bs_q;
  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] zc;
  logic [7:0] tidx;
  logic [ActW-1:0] act_val;
  logic wr_en, run;

  assign n_in = (layer_q == 2'd0) ? 6'(Inputs) : 6'(Hidden);
  assign n_out = (layer_q == 2'd2) ? 5'(Classes) : 5'(Hidden);

  always_comb begin
    unique case (layer_q)
      2'd0: raddr = AddrW'(OffW1 + 32'(row_q) * Inputs + 32'(col_q));
      2'd1: raddr = AddrW'(OffW2 + 32'(row_q) * Hidden + 32'(col_q));
      default: raddr = AddrW'(OffW3 + 32'(row_q) * Hidden + 32'(col_q));
    endcase
    if (st_q == ST_BIAS || col_q == n_in) begin
      unique case (layer_q)
        2'd0: raddr = AddrW'(OffB1 + 32'(row_q));
        2'd1: raddr = AddrW'(OffB2 + 32'(row_q));
        default: raddr = AddrW'(OffB3 + 32'(row_q));
      endcase
    end
  end

  always_comb begin
    unique case (layer_q)
      2'd0: act_sel = feat_q[pcol_q[4:0]];
      2'd1: act_sel = h1_q[pcol_q[3:0]];
      default: act_sel = h2_q[pcol_q[3:0]];
    endcase
  end

  assign prod = AccW'(rdata_q) * $signed({1'b0, act_sel});

  always_comb begin
    zc = acc_q + 48'sd524288;
    if (acc_q < -48'sd524288) tidx = 8'd0;
    else if (acc_q >= 48'sd524288) tidx = 8'd255;
    else tidx = zc[19:12];
  end
  assign act_val = sig_lut(tidx);

  assign q_ready_o = (st_q == ST_IDLE);
  assign run = q_valid_i && q_ready_o;
  assign wr_en = run && q_job_i.func == FUNC_PARAM;

  always_comb begin
    st_d = st_q; layer_d = layer_q; row_d = row_q; col_d = col_q;
    unique case (st_q)
      ST_IDLE: begin
        if (run && q_job_i.func == FUNC_FEATURE &&
            32'(q_job_i.fidx) == Inputs - 1) begin
          st_d = ST_MAC; layer_d = 2'd0; row_d = '0; col_d = '0;
        end
      end
      ST_MAC: begin
        if (col_q == n_in) st_d = ST_BIAS;
        else col_d = col_q + 6'd1;
      end
      ST_BIAS: st_d = ST_ACT;
      ST_ACT: begin
        col_d = '0;
        st_d = ST_MAC;
        if (row_q == n_out - 5'd1) begin
          row_d = '0;
          if (layer_q == 2'd2) st_d = ST_EMIT;
          else layer_d = layer_q + 2'd1;
        end else row_d = row_q + 5'd1;
      end
      ST_EMIT: begin
        if (out_ready_i && 32'(k_q) == Classes - 1) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; layer_q <= '0; row_q <= '0; col_q <= '0;
      pend_q <= 1'b0; k_q <= '0;
    end else begin
      st_q <= st_d; layer_q <= layer_d; row_q <= row_d; col_q <= col_d;
      pend_q <= (st_q == ST_MAC) && (col_q != n_in);
      if (st_q != ST_EMIT) k_q <= '0;
      else if (out_ready_i) k_q <= k_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) wmem[q_job_i.addr] <= q_job_i.value;
    rdata_q <= wmem[raddr];
    pcol_q <= col_q;
    if (run && q_job_i.func == FUNC_FEATURE) feat_q[q_job_i.fidx] <= q_job_i.fval;
    if (st_q == ST_MAC && col_q == 6'd0) acc_q <= '0;
    else if (pend_q) acc_q <= acc_q + prod;
    // bias word arrives the cycle after the MAC loop ends
    if (st_q == ST_BIAS) acc_q <= acc_q + (AccW'(rdata_q) <<< 8);
    if (st_q == ST_ACT) begin
      unique case (layer_q)
        2'd0: h1_q[row_q[3:0]] <= act_val;
        2'd1: h2_q[row_q[3:0]] <= act_val;
        default: sc_q[row_q[3:0]] <= act_val;
      endcase
      if (layer_q == 2'd2) begin
        if (row_q == 5'd0) begin
          if (act_val > 9'd0) begin bc_q <= '0; bs_q <= act_val; end
          else begin bc_q <= ClassW'(Classes - 1); bs_q <= '0; end
        end else if (act_val > bs_q) begin
          bc_q <= row_q[ClassW-1:0]; bs_q <= act_val;
        end
      end
    end
  end

  assign out_valid_o = (st_q == ST_EMIT);
  assign class_index_o = k_q;
  assign class_score_o = sc_q[k_q];
  assign last_o = (32'(k_q) == Classes - 1);
  assign best_class_o = last_o ? bc_q : '0;
  assign best_score_o = last_o ? bs_q : '0;
endmodule
`default_nettype wire

[src/mlp_sigmoid_classifier.sv]
// Top level: three-layer sigmoid perceptron classifier over a stream port.
// Input beats: tuser = func (0 parameter word, 1 feature element).
// A parameter beat writes one Q8.8 word to the weight store (w1,b1,w2,b2,
// w3,b3 order); a feature beat fills the 32-entry feature buffer, and the
// feature with index 31 starts a pass.
// A front queue of four beats decouples acceptance from the compute engine.
// One shared multiply-accumulate serves all layers, one product a cycle;
// after the last layer, a pass emits 12 score beats, class 0 first; the
// twelfth carries tlast and the argmax. Parameter and ordinary feature
// beats are taken by the engine only while it is idle.
// If the receiver stalls, the engine holds the current beat and the queue
// fills, then tready drops. Reset empties the queue and idles the engine;
// stores keep no reset values and must be written before a pass.
`default_nettype none
module mlp_sigmoid_classifier import mlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [9:0] param_addr, [25:10] param_value, [30:26] feature_index,
  // [39:31] feature_value
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,  // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] class_index, [12:4] class_score, [16:13] best_class,
  // [25:17] best_score
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast   // last_of_run
);
  job_t in_job, q_job;
  logic q_valid, q_ready;
  logic [ClassW-1:0] ci, bc;
  logic [ActW-1:0] cs, bs;

  assign in_job.func = func_e'(s_axis_tuser);
  assign in_job.addr = s_axis_tdata[9:0];
  assign in_job.value = s_axis_tdata[25:10];
  assign in_job.fidx = s_axis_tdata[30:26];
  assign in_job.fval = s_axis_tdata[39:31];

  mlp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_job_i(in_job),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_job_o(q_job)
  );

  mlp_engine u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_job_i(q_job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .class_index_o(ci), .class_score_o(cs), .best_class_o(bc),
    .best_score_o(bs), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, bs, bc, cs, ci};

  a_last_only_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'(Classes - 1))
    else $error("tlast on wrong class");
  a_no_input_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !q_ready)
    else $error("engine took a job while emitting");
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:4] <= 9'd256)
    else $error("score out of range");
endmodule
`default_nettype wire
